### design/xtea_pkg.sv
package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned NUM_CELLS = 2 * ROUNDS;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [$clog2(KEY_WORDS)-1:0] key_idx_t;
  typedef word_t [KEY_WORDS-1:0] key_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD0 = 8'd0,
    CFG_KEY_WORD1 = 8'd1,
    CFG_KEY_WORD2 = 8'd2,
    CFG_KEY_WORD3 = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic  mode;
    word_t left_word;
    word_t right_word;
  } in_t;

  typedef struct packed {
    word_t left_out;
    word_t right_out;
  } out_t;

  // x is the half updated in a cell, y the half that feeds the round function
  typedef struct packed {
    logic  mode;
    word_t x;
    word_t y;
  } slice_t;

  typedef struct packed {
    word_t    enc_sum;
    key_idx_t enc_idx;
    word_t    dec_sum;
    key_idx_t dec_idx;
  } cell_cst_t;

  function automatic cell_cst_t cell_cst(input int unsigned stage);
    cell_cst_t   c;
    int unsigned rnd;
    word_t       s;
    rnd = stage >> 1;
    if ((stage & 1) == 0) begin
      s = word_t'(rnd) * DELTA;
      c.enc_sum = s;
      c.enc_idx = s[1:0];
      s = word_t'(ROUNDS - rnd) * DELTA;
      c.dec_sum = s;
      c.dec_idx = s[12:11];
    end else begin
      s = word_t'(rnd + 1) * DELTA;
      c.enc_sum = s;
      c.enc_idx = s[12:11];
      s = word_t'(ROUNDS - 1 - rnd) * DELTA;
      c.dec_sum = s;
      c.dec_idx = s[1:0];
    end
    return c;
  endfunction

endpackage

### design/xtea_cell.sv
module xtea_cell
  import xtea_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  key_t      key_i,
  input  cell_cst_t cst_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  slice_t    data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output slice_t    data_o
);

  logic   valid_q;
  slice_t data_q, data_d;
  word_t  mix, rkey, fval;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    mix  = ((data_i.y << 4) ^ (data_i.y >> 5)) + data_i.y;
    rkey = data_i.mode ? cst_i.dec_sum + key_i[cst_i.dec_idx]
                       : cst_i.enc_sum + key_i[cst_i.enc_idx];
    fval = mix ^ rkey;
    data_d.mode = data_i.mode;
    data_d.x    = data_i.y;
    data_d.y    = data_i.mode ? data_i.x - fval : data_i.x + fval;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/xtea_block_cipher_core.sv
// Channel | Direction | Handshake              | Payload
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_idx_i, cfg_data_i (key word 0..3)
// in      | in        | in_valid_i/in_ready_o   | in_data_i (in_t)
// out     | out       | out_valid_o/out_ready_i | out_data_o (out_t)
//
// One transaction per cycle sustained while out_ready_i is high; 64 registered half-round cells.
// Each cell holds its own slice and stalls only when it is full and its successor
// is stalled, so bubbles close up and input keeps flowing while a result waits.
// Reset clears the key words to zero and empties every cell.
// Key writes are registered and apply to every cell, blocks in flight too; cfg_ready_o is always high.
module xtea_block_cipher_core
  import xtea_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  word_t                cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  key_t   key_q;
  logic   chain_valid [NUM_CELLS+1];
  logic   chain_ready [NUM_CELLS+1];
  slice_t chain_data  [NUM_CELLS+1];
  slice_t tail;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_KEY_WORD0: key_q[0] <= cfg_data_i;
        CFG_KEY_WORD1: key_q[1] <= cfg_data_i;
        CFG_KEY_WORD2: key_q[2] <= cfg_data_i;
        CFG_KEY_WORD3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decrypt enters with halves swapped so every cell updates x from y
  assign chain_valid[0]     = in_valid_i;
  assign in_ready_o         = chain_ready[0];
  assign chain_data[0].mode = in_data_i.mode;
  assign chain_data[0].x    = in_data_i.mode ? in_data_i.right_word : in_data_i.left_word;
  assign chain_data[0].y    = in_data_i.mode ? in_data_i.left_word : in_data_i.right_word;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    localparam cell_cst_t Cst = cell_cst(g);
    xtea_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .cst_i   (Cst),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  assign tail                 = chain_data[NUM_CELLS];
  assign out_valid_o          = chain_valid[NUM_CELLS];
  assign chain_ready[NUM_CELLS] = out_ready_i;
  assign out_data_o.left_out  = tail.mode ? tail.y : tail.x;
  assign out_data_o.right_out = tail.mode ? tail.x : tail.y;

endmodule

### dv/tb_xtea_block_cipher_core.sv
`timescale 1ns / 100ps

module tb_xtea_block_cipher_core;
  import xtea_pkg::*;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_BLOCKS = 165;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  word_t                cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;

  key_t  key_copy = '0;
  in_t   pending_blocks[$];
  out_t  predicted_blocks[$];
  out_t  head_blk;
  int    mismatch_cnt = 0;
  int    gap_cnt = 0;
  int    stall_cnt = 0;
  int    send_gap_max = 0;
  int    recv_stall_max = 0;
  bit    send_hold = 1'b0;

  xtea_block_cipher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic word_t round_mix(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic out_t xtea_transform(input in_t blk);
    word_t a;
    word_t b;
    word_t s;
    out_t  res;
    a = blk.left_word;
    b = blk.right_word;
    if (blk.mode == MODE_DEC) begin
      s = word_t'(ROUNDS) * DELTA;
      for (int i = 0; i < ROUNDS; i++) begin
        b -= round_mix(a) ^ (s + key_copy[s[12:11]]);
        s -= DELTA;
        a -= round_mix(b) ^ (s + key_copy[s[1:0]]);
      end
    end else begin
      s = '0;
      for (int i = 0; i < ROUNDS; i++) begin
        a += round_mix(b) ^ (s + key_copy[s[1:0]]);
        s += DELTA;
        b += round_mix(a) ^ (s + key_copy[s[12:11]]);
      end
    end
    res.left_out  = a;
    res.right_out = b;
    return res;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input out_t got, input out_t exp);
    $display("%0t mismatch (%s): got %08h_%08h expected %08h_%08h", $time, what,
             got.left_out, got.right_out, exp.left_out, exp.right_out);
    mismatch_cnt++;
  endtask

  task automatic push_block(input logic mode, input word_t l, input word_t r);
    pending_blocks.push_back('{mode: mode, left_word: l, right_word: r});
  endtask

  // push a block for encryption and its predicted ciphertext for decryption
  task automatic push_round_trip(input word_t l, input word_t r);
    out_t c;
    c = xtea_transform('{mode: MODE_ENC, left_word: l, right_word: r});
    push_block(MODE_ENC, l, r);
    push_block(MODE_DEC, c.left_out, c.right_out);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < KEY_WORDS) key_copy[key_idx_t'(idx)] = data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_key(input key_t k, input logic [CFG_IDX_W-1:0] stray_idx);
    write_key_reg(CFG_KEY_WORD0, k[0]);
    write_key_reg(CFG_KEY_WORD1, k[1]);
    write_key_reg(CFG_KEY_WORD2, k[2]);
    write_key_reg(CFG_KEY_WORD3, k[3]);
    write_key_reg(stray_idx, $urandom);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_blocks.size() != 0 || in_valid_i || predicted_blocks.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_blocks.push_back(xtea_transform(in_data_i));
        gap_cnt = $urandom_range(0, send_gap_max);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the current transaction
      end else if (gap_cnt != 0) begin
        gap_cnt--;
        in_valid_i <= 1'b0;
      end else if (pending_blocks.size() != 0 && !send_hold) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_blocks.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_blocks.size() == 0) begin
          report_mismatch("result with nothing pending", out_data_o, '0);
        end else begin
          head_blk = predicted_blocks.pop_front();
          if (out_data_o.left_out !== head_blk.left_out)
            report_mismatch("left_out", out_data_o, head_blk);
          if (out_data_o.right_out !== head_blk.right_out)
            report_mismatch("right_out", out_data_o, head_blk);
        end
        stall_cnt = $urandom_range(0, recv_stall_max);
      end
      if (stall_cnt != 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    key_t k;
    int   n;
    word_t l;
    word_t r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key of all zeros
    @(negedge clk_i);
    for (int m = 0; m < 2; m++) begin
      push_block(m[0], '0, '0);
      push_block(m[0], '1, '1);
      push_block(m[0], '0, '1);
      push_block(m[0], '1, '0);
      push_block(m[0], 32'h8000_0000, 32'h0000_0001);
      push_block(m[0], 32'h0000_0001, 32'h8000_0000);
      push_block(m[0], 32'hAAAA_AAAA, 32'h5555_5555);
    end
    push_round_trip($urandom, $urandom);
    push_round_trip('1, '0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: k = '1;
        1: k = '0;
        3: k = {word_t'('1), word_t'(0), word_t'('1), word_t'(0)};
        default: k = {pick_word(), pick_word(), pick_word(), pick_word()};
      endcase
      set_key(k, (p == 0) ? {CFG_IDX_W{1'b1}}
                          : CFG_IDX_W'($urandom_range(KEY_WORDS, 2**CFG_IDX_W - 1)));
      @(negedge clk_i);
      send_gap_max   = (p % 2 == 1) ? 9 : 0;
      recv_stall_max = ((p / 2) % 2 == 1) ? 9 : 0;
      if (p < 3) push_round_trip('0, '0);
      n = 0;
      while (n < PHASE_BLOCKS) begin
        l = pick_word();
        r = pick_word();
        if ($urandom_range(0, 7) == 0) begin
          push_round_trip(l, r);
          n += 2;
        end else begin
          push_block(1'($urandom_range(0, 1)), l, r);
          n++;
        end
      end
      if (p == 4) begin
        do @(negedge clk_i); while (pending_blocks.size() > n / 2);
        send_hold = 1'b1;
        do @(negedge clk_i); while (in_valid_i || predicted_blocks.size() != 0);
        send_hold = 1'b0;
      end
      wait_drained();
    end

    repeat (NUM_CELLS + 16) @(posedge clk_i);
    if (predicted_blocks.size() != 0)
      report_mismatch("missing result", '0, predicted_blocks[0]);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
